[rtl/ipq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipq_pkg
// Shared types and constants of the input press qualifier.
// ----------------------------------------------------------------------------
package ipq_pkg;

    localparam int unsigned CNT_W    = 8;
    localparam int unsigned MASK_W   = 16;
    localparam int unsigned PIN_IDX_W = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX   = 3'd5;

    // register reset values
    localparam logic [CNT_W-1:0] RST_HYSTERESIS = 8'd15;
    localparam logic [CNT_W-1:0] RST_LONG_LIMIT = 8'd250;
    localparam logic [CNT_W-1:0] RST_SHORT_MIN  = 8'd10;
    localparam logic [CNT_W-1:0] RST_SHORT_MAX  = 8'd200;

    typedef enum logic [1:0] {
        KIND_RISE  = 2'd0,
        KIND_FALL  = 2'd1,
        KIND_LONG  = 2'd2,
        KIND_SHORT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_EVAL,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] held;
        logic             active;
        logic             latch;
    } t_pin_state;

    typedef struct packed {
        logic  vld;
        t_kind kind;
    } t_evt;

    typedef struct packed {
        logic [CNT_W-1:0] hysteresis;
        logic [CNT_W-1:0] long_limit;
        logic [CNT_W-1:0] short_min;
        logic [CNT_W-1:0] short_max;
    } t_cfg;

endpackage
`default_nettype wire

[rtl/ipq_pin_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipq_pin_unit
// Shared per-pin unit: integrator update on sample, event test on evaluate.
// ----------------------------------------------------------------------------
module ipq_pin_unit import ipq_pkg::*; (
    input  wire logic       i_eval,
    input  wire logic       i_level,
    input  wire logic       i_invert,
    input  wire logic       i_button,
    input  wire t_cfg       i_cfg,
    input  wire t_pin_state i_st,
    output t_pin_state      o_st,
    output t_evt            o_evt
);

    logic             w_act;
    logic [CNT_W-1:0] w_inc;
    logic [CNT_W-1:0] w_dec;
    logic [CNT_W-1:0] w_diff;
    logic [CNT_W-1:0] w_rel;

    assign w_act  = i_level ^ i_invert;
    assign w_inc  = (i_st.cnt == CNT_MAX) ? i_st.cnt : i_st.cnt + 8'd1;
    assign w_dec  = (i_st.cnt == '0) ? i_st.cnt : i_st.cnt - 8'd1;
    assign w_rel  = i_st.held - i_st.cnt;
    assign w_diff = (i_st.held > i_st.cnt) ? i_st.held - i_st.cnt
                                           : i_st.cnt - i_st.held;

    always_comb begin
        o_st          = i_st;
        o_evt.vld     = 1'b0;
        o_evt.kind    = KIND_RISE;
        if (!i_eval) begin
            o_st.active = w_act;
            if (w_act) begin
                o_st.cnt = w_inc;
                if (i_button) begin
                    o_st.held = w_inc;
                end
            end else begin
                o_st.cnt = i_button ? '0 : w_dec;
            end
        end else if (i_button) begin
            if (i_st.active) begin
                if (i_st.cnt > i_cfg.long_limit) begin
                    o_evt.vld  = 1'b1;
                    o_evt.kind = KIND_LONG;
                end
            end else begin
                if (w_rel > i_cfg.short_min && w_rel < i_cfg.short_max) begin
                    o_evt.vld  = 1'b1;
                    o_evt.kind = KIND_SHORT;
                end
                o_st.held = '0;
            end
        end else if (w_diff > i_cfg.hysteresis) begin
            o_st.held = i_st.cnt;
            if (i_st.held < i_st.cnt) begin
                if (!i_st.latch) begin
                    o_st.latch = 1'b1;
                    o_evt.vld  = 1'b1;
                    o_evt.kind = KIND_RISE;
                end
            end else if (i_st.latch) begin
                o_st.latch = 1'b0;
                o_evt.vld  = 1'b1;
                o_evt.kind = KIND_FALL;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/ipq_evt_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipq_evt_out
// Holds one pending event so the last one can be marked, plus output register.
// ----------------------------------------------------------------------------
module ipq_evt_out import ipq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic                 i_flush,
    input  wire logic [PIN_IDX_W-1:0] i_pin,
    input  wire t_kind                i_kind,
    output logic                      o_stall,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [PIN_IDX_W-1:0]      o_pin_index,
    output logic [1:0]                o_event_kind,
    output logic                      o_last_event
);

    logic                 r_pend_vld;
    logic [PIN_IDX_W-1:0] r_pend_pin;
    t_kind                r_pend_kind;
    logic                 r_out_vld;
    logic [PIN_IDX_W-1:0] r_out_pin;
    t_kind                r_out_kind;
    logic                 r_out_last;

    logic w_free;
    logic w_move;

    assign w_free  = !r_out_vld || i_ready;
    assign w_move  = (i_push || i_flush) && r_pend_vld;
    assign o_stall = w_move && !w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_move && w_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (!o_stall) begin
                if (i_push) begin
                    r_pend_vld <= 1'b1;
                end else if (i_flush) begin
                    r_pend_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move && w_free) begin
            r_out_pin  <= r_pend_pin;
            r_out_kind <= r_pend_kind;
            r_out_last <= i_flush;
        end
        if (i_push && !o_stall) begin
            r_pend_pin  <= i_pin;
            r_pend_kind <= i_kind;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_pin_index  = r_out_pin;
    assign o_event_kind = r_out_kind;
    assign o_last_event = r_out_last;

endmodule
`default_nettype wire

[rtl/input_press_qualifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// input_press_qualifier
// Debounce and long/short press qualification for up to NUM_PINS inputs.
//
// Input channel (i_valid/o_ready): a beat with i_req_type 0 samples
// i_pin_levels, one with i_req_type 1 evaluates all pins and emits events.
// Output channel (o_valid/i_ready): one beat per event, o_last_event set on
// the final event of an evaluate; an evaluate with no events gives no beat.
// Configuration channel (i_cfg_valid/o_cfg_ready) is always ready; unknown
// indexes are dropped. Write only while the block is idle.
// The sequencer walks one pin a cycle through a single shared pin unit,
// pausing in an evaluate while the output stalls; an evaluate then ends in
// a flush state that releases its last event. o_ready is high only while idle.
// The output has a pending stage and a register; a stalled receiver halts
// an evaluate's pin walk until room frees.
// Reset (synchronous, active low) clears all counts, latches, the state, the
// valid flags and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module input_press_qualifier import ipq_pkg::*; #(
    parameter int unsigned NUM_PINS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_req_type,
    input  wire logic [MASK_W-1:0]    i_pin_levels,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [PIN_IDX_W-1:0]      o_pin_index,
    output logic [1:0]                o_event_kind,
    output logic                      o_last_event,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MASK_W-1:0]    i_cfg_data
);

    localparam int unsigned PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam logic [PW-1:0] LAST_PIN = PW'(NUM_PINS - 1);

    t_state             r_state, n_state;
    logic [PW-1:0]      r_pin, n_pin;
    logic [MASK_W-1:0]  r_levels;
    logic [MASK_W-1:0]  r_button_mask;
    logic [MASK_W-1:0]  r_invert_mask;
    t_cfg               r_cfg;
    t_pin_state         r_pst [NUM_PINS];

    t_pin_state w_pst_next;
    t_evt       w_evt;
    logic       w_stall;
    logic       w_step;
    logic       w_push;
    logic       w_flush;
    logic       w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_mask     <= '0;
            r_invert_mask     <= '0;
            r_cfg.hysteresis  <= RST_HYSTERESIS;
            r_cfg.long_limit  <= RST_LONG_LIMIT;
            r_cfg.short_min   <= RST_SHORT_MIN;
            r_cfg.short_max   <= RST_SHORT_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUTTON_MASK: r_button_mask    <= i_cfg_data;
                CFG_INVERT_MASK: r_invert_mask    <= i_cfg_data;
                CFG_HYSTERESIS:  r_cfg.hysteresis <= i_cfg_data[CNT_W-1:0];
                CFG_LONG_LIMIT:  r_cfg.long_limit <= i_cfg_data[CNT_W-1:0];
                CFG_SHORT_MIN:   r_cfg.short_min  <= i_cfg_data[CNT_W-1:0];
                CFG_SHORT_MAX:   r_cfg.short_max  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    ipq_pin_unit u_pin_unit (
        .i_eval   (r_state == ST_EVAL),
        .i_level  (r_levels[r_pin]),
        .i_invert (r_invert_mask[r_pin]),
        .i_button (r_button_mask[r_pin]),
        .i_cfg    (r_cfg),
        .i_st     (r_pst[r_pin]),
        .o_st     (w_pst_next),
        .o_evt    (w_evt)
    );

    ipq_evt_out u_evt_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_flush      (w_flush),
        .i_pin        (PIN_IDX_W'(r_pin)),
        .i_kind       (w_evt.kind),
        .o_stall      (w_stall),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pin_index  (o_pin_index),
        .o_event_kind (o_event_kind),
        .o_last_event (o_last_event)
    );

    // sequencer outputs
    always_comb begin
        o_ready = 1'b0;
        w_step  = 1'b0;
        w_push  = 1'b0;
        w_flush = 1'b0;
        case (r_state)
            ST_IDLE:   o_ready = 1'b1;
            ST_SAMPLE: w_step  = 1'b1;
            ST_EVAL: begin
                w_push = w_evt.vld;
                w_step = !w_stall;
            end
            ST_FLUSH:  w_flush = 1'b1;
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_pin   = r_pin;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_req_type ? ST_EVAL : ST_SAMPLE;
                    n_pin   = '0;
                end
            end
            ST_SAMPLE: begin
                n_pin = r_pin + 1'b1;
                if (r_pin == LAST_PIN) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EVAL: begin
                if (!w_stall) begin
                    n_pin = r_pin + 1'b1;
                    if (r_pin == LAST_PIN) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!w_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pin   <= '0;
        end else begin
            r_state <= n_state;
            r_pin   <= n_pin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_levels <= i_pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PINS; i++) begin
                r_pst[i] <= '0;
            end
        end else if (w_step) begin
            r_pst[r_pin] <= w_pst_next;
        end
    end

endmodule
`default_nettype wire
